// ===== rtl/rcs_pkg.sv =====
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared widths, constants and the result type of the RGB contrast stretch.
// ----------------------------------------------------------------------------
`default_nettype none

package rcs_pkg;

  // Sample width and channel count.
  localparam int unsigned PIX_W = 8;
  localparam int unsigned CH_N  = 3;

  // Width of the shared subtractor (one guard bit over a sample).
  localparam int unsigned ALU_W = PIX_W + 1;

  // Opcodes carried in the input tuser.
  localparam logic OP_ANALYZE = 1'b0;
  localparam logic OP_STRETCH = 1'b1;

  // Range values loaded at reset and on a new image.
  localparam logic [PIX_W-1:0] LOW_INIT  = 8'hFF;
  localparam logic [PIX_W-1:0] HIGH_INIT = 8'h00;

  // Largest stretched sample.
  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  // One result beat: three samples, red in the lowest byte, and the flat flag.
  typedef struct packed {
    logic                       flat;
    logic [CH_N-1:0][PIX_W-1:0] pix;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/rcs_alu.sv =====
// ----------------------------------------------------------------------------
// rcs_alu
// Shared subtract and compare unit used for every range update, the span, the
// offset from the minimum, the clamp compare and each restoring division step.
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_alu
  import rcs_pkg::*;
(
  input  wire logic [ALU_W-1:0] a,
  input  wire logic [ALU_W-1:0] b,
  output logic      [ALU_W-1:0] diff,
  output logic                  borrow,
  output logic                  zero
);

  logic [ALU_W:0] full;

  // One guard bit gives the borrow, so a < b reads straight off the top bit.
  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[ALU_W-1:0];
  assign borrow = full[ALU_W];
  assign zero   = (full == '0);

endmodule

`default_nettype wire

// ===== rtl/rcs_obuf.sv =====
// ----------------------------------------------------------------------------
// rcs_obuf
// Output register for result beats; holds a beat while the receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_obuf
  import rcs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   load,
  input  wire res_t                   res,
  output logic                        free,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [CH_N*PIX_W-1:0]       out_tdata,
  output logic                        out_tuser
);

  logic valid_r;
  logic valid_nxt;
  res_t data_r;

  // The register can take a beat when empty or when its beat leaves now.
  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r.pix;
  assign out_tuser  = data_r.flat;

endmodule

`default_nettype wire

// ===== rtl/rgb_contrast_stretch.sv =====
// ----------------------------------------------------------------------------
// rgb_contrast_stretch
// Global min/max contrast stretch of RGB pixels with one shared subtractor.
// ----------------------------------------------------------------------------
// Usage: the same pixel stream is sent twice. Analyze beats (in_tuser[0] = 0)
// fold each pixel into one running minimum and maximum shared by all three
// channels; in_tuser[1] set on an analyze beat starts a new image. Stretch
// beats (in_tuser[0] = 1) return one result beat each, every channel mapped to
// (p - min) * 256 / (max - min) and clamped to 0..255. out_tuser flags a flat
// range (max <= min), in which case all samples are 0.
// Timing: a single 9-bit subtractor does all the work under a sequencer, so
// one beat is taken at a time. An analyze beat keeps in_tready low while it
// makes two compares per channel, one for the minimum and one for the maximum.
// A stretch beat keeps in_tready low through the span step, then per channel
// a subtract (sample at or below min), a subtract and a compare (clamped at
// 255) or both followed by a restoring division (one quotient bit a cycle),
// then the hand-off of the result to the output register, which waits while
// that register is full. The result beat is offered, and in_tready rises
// again, in the cycle after the hand-off.
// Reset sets the range to min 255, max 0 and empties the output register.
// A stalled receiver holds the result in the output register; the next beat
// is still accepted, and only a second finished result waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_contrast_stretch
  import rcs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input channel.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [CH_N*PIX_W-1:0]  in_tdata,   // red_in, green_in, blue_in
  input  wire logic [1:0]             in_tuser,   // opcode, restart
  // Result channel.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [CH_N*PIX_W-1:0]       out_tdata,  // red_out, green_out, blue_out
  output logic                        out_tuser   // flat_range
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_AN   = 3'd1;
  localparam logic [2:0] S_SPAN = 3'd2;
  localparam logic [2:0] S_SUB  = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  localparam logic [1:0] CH_LAST  = 2'(CH_N - 1);
  localparam logic [2:0] DIV_LAST = 3'(PIX_W - 1);

  logic [2:0]                 state_r, state_nxt;
  logic [1:0]                 ch_r, ch_nxt;
  logic [2:0]                 cnt_r, cnt_nxt;
  logic [CH_N-1:0][PIX_W-1:0] px_r, px_nxt;
  logic [CH_N-1:0][PIX_W-1:0] res_r, res_nxt;
  logic [PIX_W-1:0]           lo_r, lo_nxt;
  logic [PIX_W-1:0]           hi_r, hi_nxt;
  logic [PIX_W-1:0]           span_r, span_nxt;
  logic [ALU_W-1:0]           rem_r, rem_nxt;
  logic [PIX_W-1:0]           q_r, q_nxt;
  logic                       flat_r, flat_nxt;

  logic [ALU_W-1:0] alu_a, alu_b, alu_diff;
  logic             alu_borrow, alu_zero;
  logic [PIX_W-1:0] cur_px;
  logic [PIX_W-1:0] q_step;
  logic             obuf_free, obuf_load;
  logic             in_beat;
  res_t             res_beat;

  assign in_tready = (state_r == S_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign cur_px    = px_r[ch_r];
  assign q_step    = {q_r[PIX_W-2:0], !alu_borrow};

  // Shared subtract and compare unit.
  rcs_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .diff   (alu_diff),
    .borrow (alu_borrow),
    .zero   (alu_zero)
  );

  // Operand selection for the shared unit.
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state_r)
      S_AN: begin
        if (!cnt_r[0]) begin
          alu_a = {1'b0, cur_px};
          alu_b = {1'b0, lo_r};
        end else begin
          alu_a = {1'b0, hi_r};
          alu_b = {1'b0, cur_px};
        end
      end
      S_SPAN: begin
        alu_a = {1'b0, hi_r};
        alu_b = {1'b0, lo_r};
      end
      S_SUB: begin
        alu_a = {1'b0, cur_px};
        alu_b = {1'b0, lo_r};
      end
      S_CMP: begin
        alu_a = rem_r;
        alu_b = {1'b0, span_r};
      end
      S_DIV: begin
        alu_a = {rem_r[ALU_W-2:0], 1'b0};
        alu_b = {1'b0, span_r};
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  // Sequencer and datapath next state.
  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    cnt_nxt   = cnt_r;
    px_nxt    = px_r;
    res_nxt   = res_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    span_nxt  = span_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    flat_nxt  = flat_r;
    obuf_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          px_nxt   = in_tdata;
          ch_nxt   = '0;
          cnt_nxt  = '0;
          flat_nxt = 1'b0;
          if (in_tuser[0] == OP_ANALYZE) begin
            if (in_tuser[1]) begin
              lo_nxt = LOW_INIT;
              hi_nxt = HIGH_INIT;
            end
            state_nxt = S_AN;
          end else begin
            state_nxt = S_SPAN;
          end
        end
      end
      // Even step updates the minimum, odd step the maximum of one channel.
      S_AN: begin
        if (!cnt_r[0]) begin
          if (alu_borrow) begin
            lo_nxt = cur_px;
          end
          cnt_nxt = 3'd1;
        end else begin
          if (alu_borrow) begin
            hi_nxt = cur_px;
          end
          cnt_nxt = '0;
          if (ch_r == CH_LAST) begin
            ch_nxt    = '0;
            state_nxt = S_IDLE;
          end else begin
            ch_nxt = ch_r + 2'd1;
          end
        end
      end
      // Span of the range; an empty or flat range gives zeros and the flag.
      S_SPAN: begin
        if (alu_borrow || alu_zero) begin
          flat_nxt  = 1'b1;
          res_nxt   = '0;
          state_nxt = S_EMIT;
        end else begin
          span_nxt  = alu_diff[PIX_W-1:0];
          state_nxt = S_SUB;
        end
      end
      // Offset from the minimum; at or below it the sample maps to 0.
      S_SUB: begin
        if (alu_borrow || alu_zero) begin
          res_nxt[ch_r] = '0;
          if (ch_r == CH_LAST) begin
            state_nxt = S_EMIT;
          end else begin
            ch_nxt = ch_r + 2'd1;
          end
        end else begin
          rem_nxt   = alu_diff;
          state_nxt = S_CMP;
        end
      end
      // An offset of at least the span gives a quotient of 256 or more.
      S_CMP: begin
        if (!alu_borrow) begin
          res_nxt[ch_r] = PIX_MAX;
          if (ch_r == CH_LAST) begin
            state_nxt = S_EMIT;
          end else begin
            ch_nxt    = ch_r + 2'd1;
            state_nxt = S_SUB;
          end
        end else begin
          cnt_nxt   = '0;
          q_nxt     = '0;
          state_nxt = S_DIV;
        end
      end
      // Restoring division, one quotient bit per cycle.
      S_DIV: begin
        q_nxt   = q_step;
        rem_nxt = alu_borrow ? alu_a : alu_diff;
        if (cnt_r == DIV_LAST) begin
          cnt_nxt       = '0;
          res_nxt[ch_r] = q_step;
          if (ch_r == CH_LAST) begin
            state_nxt = S_EMIT;
          end else begin
            ch_nxt    = ch_r + 2'd1;
            state_nxt = S_SUB;
          end
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      // Hand the result to the output register once it has room.
      S_EMIT: begin
        if (obuf_free) begin
          obuf_load = 1'b1;
          ch_nxt    = '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and the image range.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= '0;
      cnt_r   <= '0;
      lo_r    <= LOW_INIT;
      hi_r    <= HIGH_INIT;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      cnt_r   <= cnt_nxt;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
    end
  end

  // Working registers of the current beat.
  always_ff @(posedge clk) begin
    px_r   <= px_nxt;
    res_r  <= res_nxt;
    span_r <= span_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    flat_r <= flat_nxt;
  end

  assign res_beat.pix  = res_r;
  assign res_beat.flat = flat_r;

  // Output register.
  rcs_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (obuf_load),
    .res        (res_beat),
    .free       (obuf_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ===== rtl/rcs_checker.sv =====
// ----------------------------------------------------------------------------
// rcs_checker
// Port-level checks of the RGB contrast stretch, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_checker
  import rcs_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [CH_N*PIX_W-1:0] out_tdata,
  input wire logic                  out_tuser
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // A flat range always comes with all samples at zero.
  a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("flat range with nonzero samples");

  // Every input beat keeps the block busy for at least the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on back-to-back cycles");

endmodule

bind rgb_contrast_stretch rcs_checker u_rcs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the RGB contrast stretch.
// ----------------------------------------------------------------------------
// Pixels go in as analyze and stretch beats. A monitor on both channels keeps
// its own running minimum and maximum, predicts each stretched pixel at the
// moment its stretch beat is taken, and compares every result beat, channel
// by channel, with the oldest prediction. Directed tests cover the reset
// range, full-scale samples, flat ranges, clamping at both ends and a restart
// flag on a stretch beat. Random images follow, two passes each, mixed with
// stray beats and broken sequences, under bursty idling on both sides. The
// run ends with a stretch of images at full rate.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import rcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Beats of random images before the final full-rate part.
  localparam int unsigned RANDOM_ITEMS = 1650;
  // Beats of the final full-rate part.
  localparam int unsigned UNSTALLED_ITEMS = 100;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int unsigned HANG_LIMIT = 4000;
  // Quiet cycles after the last result: the slowest stretch plus margin.
  localparam int unsigned SETTLE_CYCLES = 40;

  // Pixel content of a random image.
  typedef enum int unsigned {
    IMG_FULL,
    IMG_NARROW,
    IMG_FLAT
  } img_style_e;

  logic clk = 1'b0;
  logic rst_n;

  logic                  in_tvalid;
  logic                  in_tready;
  logic [CH_N*PIX_W-1:0] in_tdata;   // red_in, green_in, blue_in
  logic [1:0]            in_tuser;   // opcode, restart
  logic                  out_tvalid;
  logic                  out_tready;
  logic [CH_N*PIX_W-1:0] out_tdata;  // red_out, green_out, blue_out
  logic                  out_tuser;  // flat_range

  // Predicted result beats, oldest first.
  res_t stretched_q[$];

  // Running range as the design should hold it.
  logic [PIX_W-1:0] range_lo;
  logic [PIX_W-1:0] range_hi;

  int unsigned errors;
  int unsigned sent_items;
  int unsigned quiet_cycles;
  int unsigned rx_stall;
  bit          tx_idle_en;
  bit          rx_idle_en;

  string chan_name[CH_N] = '{"red", "green", "blue"};

  rgb_contrast_stretch dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stretch one sample over a nonzero span, clamped to the sample range.
  function automatic logic [PIX_W-1:0] stretch_sample(logic [PIX_W-1:0] p,
                                                      logic [PIX_W-1:0] lo,
                                                      logic [PIX_W-1:0] span);
    int unsigned q;
    if (p <= lo) begin
      return '0;
    end
    q = ((int'(p) - int'(lo)) * 256) / int'(span);
    return (q > PIX_MAX) ? PIX_MAX : q[PIX_W-1:0];
  endfunction

  // Receiver: ready with random stall bursts while idling is enabled.
  always @(negedge clk) begin
    if (rx_stall != 0) begin
      rx_stall   = rx_stall - 1;
      out_tready = 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
      rx_stall   = $urandom_range(1, 16) - 1;
      out_tready = 1'b0;
    end else begin
      out_tready = 1'b1;
    end
  end

  // Monitor: check result beats, then fold accepted input beats into the
  // predicted range or the expectation queue, and watch for a hang.
  always @(posedge clk) begin : scoreboard
    res_t                       want;
    res_t                       got;
    logic [CH_N-1:0][PIX_W-1:0] px;
    bit                         flat;
    if (!rst_n) begin
      range_lo     = LOW_INIT;
      range_hi     = HIGH_INIT;
      quiet_cycles = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.pix  = out_tdata;
        got.flat = out_tuser;
        if (stretched_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none, actual tdata %h tuser %b",
                   $realtime, out_tdata, out_tuser);
        end else begin
          want = stretched_q.pop_front();
          for (int c = 0; c < CH_N; c++) begin
            if (got.pix[c] !== want.pix[c]) begin
              errors++;
              $display("%0t: %s_out mismatch, expected %0d actual %0d",
                       $realtime, chan_name[c], want.pix[c], got.pix[c]);
            end
          end
          if (got.flat !== want.flat) begin
            errors++;
            $display("%0t: flat_range mismatch, expected %b actual %b",
                     $realtime, want.flat, got.flat);
          end
        end
      end

      if (in_tvalid && in_tready) begin
        px = in_tdata;
        if (in_tuser[0] == OP_ANALYZE) begin
          if (in_tuser[1]) begin
            range_lo = LOW_INIT;
            range_hi = HIGH_INIT;
          end
          for (int c = 0; c < CH_N; c++) begin
            if (px[c] < range_lo) range_lo = px[c];
            if (px[c] > range_hi) range_hi = px[c];
          end
        end else begin
          flat      = (range_hi <= range_lo);
          want.flat = flat;
          for (int c = 0; c < CH_N; c++) begin
            want.pix[c] = flat ? '0 : stretch_sample(px[c], range_lo, range_hi - range_lo);
          end
          stretched_q.push_back(want);
        end
      end

      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles == HANG_LIMIT) begin
          $display("%0t: no beat accepted for %0d cycles", $realtime, HANG_LIMIT);
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  // Send one pixel beat, with an optional idle burst ahead of it.
  task automatic send_pixel(input logic op, input logic restart,
                            input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] b);
    @(negedge clk);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {b, g, r};
    in_tuser  = {restart, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_items++;
  endtask

  // Let every predicted result arrive, then give the design time to settle.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (stretched_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Range straight out of reset is empty, so any stretch is flat.
  task automatic test_reset_range();
    send_pixel(OP_STRETCH, 1'b0, 8'd255, 8'd0, 8'd128);
  endtask

  // Full-scale range: a sample at the maximum maps to 256 and clamps.
  task automatic test_extremes();
    send_pixel(OP_ANALYZE, 1'b1, 8'd0, 8'd255, 8'd0);
    send_pixel(OP_STRETCH, 1'b0, 8'd0, 8'd255, 8'd128);
    send_pixel(OP_STRETCH, 1'b0, 8'd1, 8'd254, 8'd255);
    send_pixel(OP_STRETCH, 1'b0, 8'd127, 8'd64, 8'd192);
  endtask

  // A single gray level gives a flat range: zero output and the flag.
  task automatic test_flat_range();
    send_pixel(OP_ANALYZE, 1'b1, 8'd100, 8'd100, 8'd100);
    send_pixel(OP_STRETCH, 1'b0, 8'd99, 8'd100, 8'd101);
    send_pixel(OP_STRETCH, 1'b0, 8'd255, 8'd0, 8'd100);
  endtask

  // Samples outside the analyzed range clamp to 0 and to 255.
  task automatic test_clamping();
    send_pixel(OP_ANALYZE, 1'b1, 8'd50, 8'd60, 8'd70);
    send_pixel(OP_ANALYZE, 1'b0, 8'd80, 8'd200, 8'd90);
    send_pixel(OP_STRETCH, 1'b0, 8'd10, 8'd250, 8'd50);
    send_pixel(OP_STRETCH, 1'b0, 8'd200, 8'd125, 8'd51);
    // One-step span: every sample above the minimum saturates.
    send_pixel(OP_ANALYZE, 1'b1, 8'd30, 8'd30, 8'd31);
    send_pixel(OP_STRETCH, 1'b0, 8'd31, 8'd30, 8'd32);
    send_pixel(OP_STRETCH, 1'b0, 8'd29, 8'd0, 8'd255);
  endtask

  // The restart flag on a stretch beat must leave the range alone.
  task automatic test_stretch_restart();
    send_pixel(OP_ANALYZE, 1'b1, 8'd20, 8'd240, 8'd128);
    send_pixel(OP_STRETCH, 1'b1, 8'd120, 8'd130, 8'd140);
    send_pixel(OP_STRETCH, 1'b0, 8'd20, 8'd240, 8'd21);
    // Analyze without restart widens the current range.
    send_pixel(OP_ANALYZE, 1'b0, 8'd5, 8'd250, 8'd100);
    send_pixel(OP_STRETCH, 1'b1, 8'd5, 8'd250, 8'd6);
  endtask

  // One image: optional analyze pass, then a stretch pass of the same pixels.
  // A stretch pixel is sometimes replaced by a fresh one to leave the range.
  task automatic run_image(input img_style_e style, input int unsigned pixels,
                           input bit new_image, input bit analyze_pass);
    logic [CH_N*PIX_W-1:0] img[$];
    logic [CH_N*PIX_W-1:0] px;
    int unsigned           base;
    int unsigned           spread;
    int unsigned           level;
    logic [31:0]           rnd;
    base   = $urandom_range(0, 255);
    spread = $urandom_range(0, 15);
    for (int i = 0; i < pixels; i++) begin
      for (int c = 0; c < CH_N; c++) begin
        case (style)
          IMG_FULL: begin
            px[c*PIX_W +: PIX_W] = PIX_W'($urandom_range(0, 255));
          end
          IMG_NARROW: begin
            level                = base + $urandom_range(0, spread);
            px[c*PIX_W +: PIX_W] = (level > 255) ? PIX_MAX : level[PIX_W-1:0];
          end
          default: begin
            px[c*PIX_W +: PIX_W] = base[PIX_W-1:0];
          end
        endcase
      end
      img.push_back(px);
    end
    if (analyze_pass) begin
      foreach (img[i]) begin
        send_pixel(OP_ANALYZE, (i == 0) && new_image,
                   img[i][7:0], img[i][15:8], img[i][23:16]);
      end
    end
    foreach (img[i]) begin
      rnd = $urandom();
      px  = ($urandom_range(0, 7) == 0) ? rnd[CH_N*PIX_W-1:0] : img[i];
      send_pixel(OP_STRETCH, 1'($urandom_range(0, 1)), px[7:0], px[15:8], px[23:16]);
    end
  endtask

  // Random images under bursty idling, with stray and broken sequences.
  task automatic test_random_images();
    int unsigned kind;
    while (sent_items < RANDOM_ITEMS) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      kind       = $urandom_range(0, 9);
      if (kind == 0) begin
        // Stray beats of any kind.
        repeat ($urandom_range(1, 6)) begin
          send_pixel(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                     PIX_W'($urandom_range(0, 255)));
        end
      end else if (kind == 1) begin
        // Broken: an image that merges into the last range or skips analyze.
        run_image(img_style_e'($urandom_range(0, 2)), $urandom_range(1, 8),
                  1'b0, 1'($urandom_range(0, 1)));
      end else begin
        run_image(img_style_e'($urandom_range(0, 2)), $urandom_range(1, 12),
                  1'b1, 1'b1);
      end
    end
  endtask

  // Final images with both sides always ready.
  task automatic test_unstalled_images();
    int unsigned stop_at;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    stop_at    = sent_items + UNSTALLED_ITEMS;
    while (sent_items < stop_at) begin
      run_image(img_style_e'($urandom_range(0, 2)), $urandom_range(1, 12), 1'b1, 1'b1);
    end
  endtask

  initial begin
    errors     = 0;
    sent_items = 0;
    rx_stall   = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_range();
    test_extremes();
    test_flat_range();
    test_clamping();
    test_stretch_restart();
    test_random_images();
    test_unstalled_images();
    wait_drained();

    if (errors == 0 && stretched_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== rgb_contrast_stretch.f =====
rtl/rcs_pkg.sv
rtl/rcs_alu.sv
rtl/rcs_obuf.sv
rtl/rgb_contrast_stretch.sv
rtl/rcs_checker.sv
tb/sv/tb_top.sv
